// ===== rtl/lmssl_pkg.sv =====
package lmssl_pkg;

	localparam int STORE_WORDS = 64;
	localparam int WORD_AW     = $clog2(STORE_WORDS);
	localparam int PAIRS       = STORE_WORDS / 2;
	localparam int PAIR_AW     = $clog2(PAIRS);

	localparam logic [2:0] KIND_SET   = 3'd0;
	localparam logic [2:0] KIND_GET   = 3'd1;
	localparam logic [2:0] KIND_CMD   = 3'd2;
	localparam logic [2:0] KIND_FLUSH = 3'd3;
	localparam logic [2:0] KIND_RAW   = 3'd4;

	localparam logic [2:0] FRAME_CMD   = 3'b100;
	localparam logic [2:0] FRAME_WRITE = 3'b101;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] x;
		logic [3:0] y;
		logic       pixel_in;
		logic [7:0] command;
		logic [6:0] address;
		logic [3:0] nibble;
	} item_t;

	typedef struct packed {
		logic [15:0] segment_bits;
		logic [4:0]  segment_count;
		logic        pixel_out;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic               rd_en;
		logic [WORD_AW-1:0] rd_addr;
		logic               wr_en;
		logic [WORD_AW-1:0] wr_addr;
		logic [3:0]         wr_data;
	} store_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX_WR,
		ST_PIX_GET,
		ST_SHIFT,
		ST_FL_RD0,
		ST_FL_RD1,
		ST_FL_CAT,
		ST_PUSH
	} state_t;

endpackage

// ===== rtl/led_matrix_shadow_serial_link.sv =====
// Shadow image of a 32 x 8 LED matrix with a serial frame builder. One item is taken
// at a time. Set pixel on the grid reads the store word, then writes it back. Get pixel
// reaches the output register through pix_q. Command and raw write frames are assembled
// four bits per cycle and then pushed to the output register. Flush sends a 10-bit
// header beat, then 32 eight-bit beats; each of those reads two words through the
// single read port of the store (FL_RD0, FL_RD1, FL_CAT) before it is pushed. The
// output register lets a new item enter while the last beat of the previous one waits
// to be taken. The store reads as all zero after reset, with no clearing pass.
module led_matrix_shadow_serial_link (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lmssl_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output lmssl_pkg::result_t result
);
	import lmssl_pkg::*;

	state_t               state_q, state_nxt;
	store_req_t           req;
	logic [3:0]           rd_data;
	logic [3:0]           wr_word;
	logic                 accept;
	logic                 push;
	logic                 in_range;

	logic [15:0]          src_q;
	logic [2:0]           dig_q;
	logic [15:0]          seg_bits_q;
	logic [4:0]           seg_count_q;
	logic                 pix_q;
	logic                 last_q;
	logic [1:0]           bit_q;
	logic                 set_val_q;
	logic                 range_q;
	logic [WORD_AW-1:0]   word_q;
	logic [PAIR_AW-1:0]   pair_q;
	logic                 out_valid_q;
	result_t              out_q;

	assign in_range = !item.x[5] && !item.y[3];
	assign accept   = item_valid && !item_stall;

	lmssl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.kind)
						KIND_SET:   state_nxt = in_range ? ST_PIX_WR : ST_IDLE;
						KIND_GET:   state_nxt = ST_PIX_GET;
						KIND_CMD:   state_nxt = ST_SHIFT;
						KIND_FLUSH: state_nxt = ST_SHIFT;
						KIND_RAW:   state_nxt = ST_SHIFT;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_PIX_WR:  state_nxt = ST_IDLE;
			ST_PIX_GET: state_nxt = ST_PUSH;
			ST_SHIFT:   state_nxt = (dig_q == 3'd1) ? ST_PUSH : ST_SHIFT;
			ST_FL_RD0:  state_nxt = ST_FL_RD1;
			ST_FL_RD1:  state_nxt = ST_FL_CAT;
			ST_FL_CAT:  state_nxt = ST_PUSH;
			ST_PUSH: begin
				if (push) begin
					state_nxt = last_q ? ST_IDLE : ST_FL_RD0;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_word        = rd_data;
		wr_word[bit_q] = set_val_q;
		item_stall     = (state_q != ST_IDLE);
		push           = 1'b0;
		req            = '0;
		req.wr_addr    = word_q;
		req.wr_data    = wr_word;
		req.rd_addr    = {item.x[4:3], item.y[2:0], item.x[2]};
		case (state_q)
			ST_IDLE: begin
				req.rd_en = item_valid && (item.kind == KIND_SET || item.kind == KIND_GET);
			end
			ST_PIX_WR: begin
				req.wr_en = 1'b1;
			end
			ST_FL_RD0: begin
				req.rd_en   = 1'b1;
				req.rd_addr = {pair_q, 1'b0};
			end
			ST_FL_RD1: begin
				req.rd_en   = 1'b1;
				req.rd_addr = {pair_q, 1'b1};
			end
			ST_PUSH: begin
				push = !out_valid_q || !result_stall;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && accept) begin
				last_q <= (item.kind != KIND_FLUSH);
			end else if (state_q == ST_FL_CAT) begin
				last_q <= (pair_q == PAIR_AW'(PAIRS - 1));
			end
		end
	end

	// Frame bits are loaded into src_q and move into the segment a nibble per cycle, top nibble first.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					seg_bits_q <= '0;
					pix_q      <= 1'b0;
					pair_q     <= '0;
					bit_q      <= ~item.x[1:0];
					set_val_q  <= item.pixel_in;
					range_q    <= in_range;
					word_q     <= {item.x[4:3], item.y[2:0], item.x[2]};
					case (item.kind)
						KIND_CMD: begin
							src_q       <= {FRAME_CMD, item.command, 1'b1, 4'd0};
							seg_count_q <= 5'd12;
							dig_q       <= 3'd3;
						end
						KIND_RAW: begin
							src_q       <= {2'd0, FRAME_WRITE, item.address, item.nibble};
							seg_count_q <= 5'd14;
							dig_q       <= 3'd4;
						end
						KIND_FLUSH: begin
							src_q       <= {2'd0, FRAME_WRITE, 7'd0, 4'd0};
							seg_count_q <= 5'd10;
							dig_q       <= 3'd3;
						end
						default: begin
							seg_count_q <= 5'd0;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				seg_bits_q <= {seg_bits_q[11:0], src_q[15:12]};
				src_q      <= {src_q[11:0], 4'd0};
				dig_q      <= dig_q - 3'd1;
			end
			ST_PIX_GET: begin
				pix_q <= range_q & rd_data[bit_q];
			end
			ST_FL_RD1: begin
				seg_bits_q <= {12'd0, rd_data};
			end
			ST_FL_CAT: begin
				seg_bits_q  <= {seg_bits_q[11:0], rd_data};
				seg_count_q <= 5'd8;
				pair_q      <= pair_q + PAIR_AW'(1);
			end
			default: begin
				seg_count_q <= seg_count_q;
			end
		endcase
		if (push) begin
			out_q.segment_bits  <= seg_bits_q;
			out_q.segment_count <= seg_count_q;
			out_q.pixel_out     <= pix_q;
			out_q.last_of_run   <= last_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/lmssl_store.sv =====
module lmssl_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lmssl_pkg::store_req_t req,
	output logic [3:0]            rd_data
);
	import lmssl_pkg::*;

	logic [3:0]             mem_q [STORE_WORDS];
	logic [STORE_WORDS-1:0] vld_q;
	logic [3:0]             rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	// A word never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 4'd0;

endmodule

// ===== verif/shadow_frame_check.sv =====
`timescale 1ns / 1ps

module shadow_frame_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  lmssl_pkg::item_t   item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  lmssl_pkg::result_t result,
	output int                 errors,
	output int                 beats_outstanding
);
	import lmssl_pkg::*;

	logic [3:0] shadow [STORE_WORDS];
	result_t    frames_due [$];
	result_t    due;

	task automatic check_field(input string tag, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
			errors++;
		end
	endtask

	// Updates the shadow image and queues the serial beats this item should produce.
	task automatic predict_beats(input item_t it);
		logic [5:0] word;
		logic [3:0] mask;
		logic       on_grid;
		result_t    beat;
		on_grid = (it.x < 6'd32) && (it.y < 4'd8);
		word = {it.x[4:3], it.y[2:0], it.x[2]};
		mask = 4'b1000 >> it.x[1:0];
		beat = '0;
		case (it.kind)
			KIND_SET: begin
				if (on_grid)
					shadow[word] = it.pixel_in ? (shadow[word] | mask) : (shadow[word] & ~mask);
			end
			KIND_GET: begin
				beat.pixel_out = on_grid && ((shadow[word] & mask) != 4'd0);
				beat.last_of_run = 1'b1;
				frames_due.push_back(beat);
			end
			KIND_CMD: begin
				beat.segment_bits = {4'b0, FRAME_CMD, it.command, 1'b1};
				beat.segment_count = 5'd12;
				beat.last_of_run = 1'b1;
				frames_due.push_back(beat);
			end
			KIND_RAW: begin
				beat.segment_bits = {2'b0, FRAME_WRITE, it.address, it.nibble};
				beat.segment_count = 5'd14;
				beat.last_of_run = 1'b1;
				frames_due.push_back(beat);
			end
			KIND_FLUSH: begin
				beat.segment_bits = {6'b0, FRAME_WRITE, 7'b0};
				beat.segment_count = 5'd10;
				frames_due.push_back(beat);
				for (int k = 0; k < PAIRS; k++) begin
					beat = '0;
					beat.segment_bits = {8'b0, shadow[2*k], shadow[2*k+1]};
					beat.segment_count = 5'd8;
					beat.last_of_run = (k == PAIRS - 1);
					frames_due.push_back(beat);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow[i])
				shadow[i] = '0;
			frames_due.delete();
			beats_outstanding = 0;
		end else begin
			if (item_valid && !item_stall)
				predict_beats(item);
			if (result_valid && !result_stall) begin
				if (frames_due.size() == 0) begin
					$display("%t: result beat with nothing expected, expected none, actual %h",
						$time, result);
					errors++;
				end else begin
					due = frames_due.pop_front();
					check_field("segment_bits", due.segment_bits, result.segment_bits);
					check_field("segment_count", due.segment_count, result.segment_count);
					check_field("pixel_out", due.pixel_out, result.pixel_out);
					check_field("last_of_run", due.last_of_run, result.last_of_run);
				end
			end
			beats_outstanding = frames_due.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import lmssl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 82;
	localparam int LONG_HOLD = 600;
	localparam int TAIL_CYCLES = 200;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int fail_count;
	int beats_outstanding;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	int phase_idle [4] = '{0, 46, 0, 36};
	int phase_stall [4] = '{0, 0, 46, 36};

	led_matrix_shadow_serial_link u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	shadow_frame_check u_frame_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.item              (item),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.result            (result),
		.errors            (fail_count),
		.beats_outstanding (beats_outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The long hold keeps the output stalled while items keep coming, so the block backs up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			result_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_beat(input item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	function automatic item_t compose(input logic [2:0] kind, input logic [5:0] x,
			input logic [3:0] y, input logic pin, input logic [7:0] cmd,
			input logic [6:0] addr, input logic [3:0] nib);
		item_t it;
		it.kind = kind;
		it.x = x;
		it.y = y;
		it.pixel_in = pin;
		it.command = cmd;
		it.address = addr;
		it.nibble = nib;
		return it;
	endfunction

	// Mostly drawing traffic on the visible grid, with frames, flushes and some junk.
	function automatic item_t rand_item();
		logic [63:0] noise;
		item_t it;
		int pick;
		noise = {$urandom, $urandom};
		it = noise[$bits(item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 42)
			it.kind = KIND_SET;
		else if (pick < 72)
			it.kind = KIND_GET;
		else if (pick < 81)
			it.kind = KIND_CMD;
		else if (pick < 90)
			it.kind = KIND_RAW;
		else if (pick < 94)
			it.kind = KIND_FLUSH;
		else
			it.kind = KIND_RAW + 3'($urandom_range(1, 3));
		if ((it.kind == KIND_SET || it.kind == KIND_GET) && $urandom_range(0, 9) != 0) begin
			it.x = 6'($urandom_range(0, 31));
			it.y = 4'($urandom_range(0, 7));
		end
		return it;
	endfunction

	initial begin
		item_t it;
		int taken;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(compose(KIND_SET, 6'd0, 4'd0, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd31, 4'd7, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd31, 4'd0, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd0, 4'd7, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd32, 4'd0, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd5, 4'd8, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd63, 4'd15, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_GET, 6'd0, 4'd0, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_GET, 6'd31, 4'd7, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_GET, 6'd32, 4'd0, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_GET, 6'd63, 4'd15, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_CMD, 6'd0, 4'd0, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_CMD, 6'd0, 4'd0, 1'b0, 8'hFF, 7'h00, 4'h0));
		send_beat(compose(KIND_RAW, 6'd0, 4'd0, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_RAW, 6'd0, 4'd0, 1'b0, 8'h00, 7'h7F, 4'hF));
		send_beat(compose(KIND_FLUSH, 6'd0, 4'd0, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_RAW + 3'd1, 6'd3, 4'd2, 1'b1, 8'hA5, 7'h11, 4'h6));
		send_beat(compose(KIND_RAW + 3'd3, 6'd3, 4'd2, 1'b1, 8'h5A, 7'h22, 4'h9));
		send_beat(compose(KIND_SET, 6'd31, 4'd7, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_GET, 6'd31, 4'd7, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_SET, 6'd17, 4'd3, 1'b1, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_FLUSH, 6'd0, 4'd0, 1'b0, 8'h00, 7'h00, 4'h0));
		send_beat(compose(KIND_GET, 6'd5, 4'd8, 1'b0, 8'h00, 7'h00, 4'h0));

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct <= phase_stall[ph];
			if (ph == 0)
				hold_req <= 1'b1;
			taken = 0;
			while (taken < ITEMS_PER_PHASE) begin
				it = rand_item();
				send_beat(it);
				if (!(it.kind > KIND_RAW ||
						(it.kind == KIND_SET && (it.x > 6'd31 || it.y > 4'd7))))
					taken++;
			end
		end
		item_valid <= 1'b0;

		// Wait for a clock edge so the checker has queued the beats of the last item.
		@(posedge clk);
		wait (beats_outstanding == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && beats_outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
